### design/wrm_pkg.sv
// window_rms_meter package: widths, limits, state encodings and shared types
// used by every file of the block; no dependencies

package wrm_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int MAX_SAMPLES = 65536;

  localparam int SQ_W    = 2 * SAMPLE_BITS;
  localparam int SUM_W   = 47;
  localparam int CNT_W   = 17;
  localparam int ROOT_W  = 16;
  localparam int REM_W   = 19;
  localparam int STEP_W  = 6;

  localparam int DIV_STEPS  = SUM_W;
  localparam int SQRT_STEPS = ROOT_W;

  localparam logic [CNT_W-1:0] MAX_COUNT = CNT_W'(MAX_SAMPLES);

  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 40;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] count;
    logic             ovf;
  } acc_t;

  typedef enum logic [2:0] {
    ST_ACC,
    ST_ADD,
    ST_LOAD,
    ST_CALC,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    ENG_IDLE,
    ENG_DIV,
    ENG_SQRT
  } eng_e;

endpackage

### design/wrm_accum.sv
// window_rms_meter accumulator: squares each sample, sums the squares and
// counts samples with saturation; depends on wrm_pkg

module wrm_accum
  import wrm_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   fire_i,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  input  logic                   clear_i,
  output acc_t                   acc_o
);

  logic [SAMPLE_BITS-1:0] mag;
  logic [SQ_W-1:0]        sq_d, sq_q;
  logic                   sq_vld_d, sq_vld_q;
  logic [SUM_W-1:0]       sum_d, sum_q;
  logic [SUM_W:0]         sum_ext;
  logic [CNT_W-1:0]       cnt_d, cnt_q;
  logic                   ovf_d, ovf_q;

  // magnitude of the most negative sample wraps to exactly 2^(bits-1)
  assign mag = sample_i[SAMPLE_BITS-1] ? SAMPLE_BITS'(~sample_i + 1'b1) : sample_i;

  assign sum_ext = {1'b0, sum_q} + (SUM_W + 1)'(sq_q);

  always_comb begin
    sq_d     = sq_q;
    sq_vld_d = 1'b0;
    cnt_d    = cnt_q;
    ovf_d    = ovf_q;
    sum_d    = sum_q;
    if (sq_vld_q) begin
      sum_d = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
    end
    if (fire_i) begin
      if (cnt_q >= MAX_COUNT) begin
        ovf_d = 1'b1;
      end else begin
        sq_d     = mag * mag;
        sq_vld_d = 1'b1;
        cnt_d    = cnt_q + 1'b1;
      end
    end
    if (clear_i) begin
      sum_d = '0;
      cnt_d = '0;
      ovf_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_vld_q <= 1'b0;
      sum_q    <= '0;
      cnt_q    <= '0;
      ovf_q    <= 1'b0;
    end else begin
      sq_vld_q <= sq_vld_d;
      sum_q    <= sum_d;
      cnt_q    <= cnt_d;
      ovf_q    <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sq_q <= sq_d;
  end

  assign acc_o.sum   = sum_q;
  assign acc_o.count = cnt_q;
  assign acc_o.ovf   = ovf_q;

endmodule

### design/wrm_sub_unit.sv
// window_rms_meter shared subtract and compare unit, used by both the
// divide and the square root steps; depends on wrm_pkg

module wrm_sub_unit
  import wrm_pkg::*;
(
  input  logic [REM_W-1:0] a_i,
  input  logic [REM_W-1:0] b_i,
  output logic [REM_W-1:0] diff_o,
  output logic             ge_o
);

  logic [REM_W:0] ext;

  assign ext    = {1'b0, a_i} - {1'b0, b_i};
  assign ge_o   = ~ext[REM_W];
  assign diff_o = ext[REM_W-1:0];

endmodule

### design/wrm_root_div.sv
// window_rms_meter iterative engine: restoring divide of the square sum by
// the count, then digit-by-digit square root, one bit per cycle through
// wrm_sub_unit; depends on wrm_pkg

module wrm_root_div
  import wrm_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [SUM_W-1:0]  dividend_i,
  input  logic [CNT_W-1:0]  divisor_i,
  output logic              done_o,
  output logic [ROOT_W-1:0] root_o
);

  eng_e              phase_d, phase_q;
  logic [STEP_W-1:0] step_d, step_q;
  logic [SUM_W-1:0]  dvd_d, dvd_q;
  logic [CNT_W-1:0]  dvs_d, dvs_q;
  logic [REM_W-1:0]  rem_d, rem_q;
  logic [ROOT_W-1:0] root_d, root_q;
  logic              done_d, done_q;
  logic [REM_W-1:0]  op_a, op_b, diff;
  logic              ge;

  wrm_sub_unit u_sub (
    .a_i   (op_a),
    .b_i   (op_b),
    .diff_o(diff),
    .ge_o  (ge)
  );

  always_comb begin
    if (phase_q == ENG_SQRT) begin
      op_a = {rem_q[REM_W-3:0], dvd_q[SUM_W-1 -: 2]};
      op_b = {1'b0, root_q, 2'b01};
    end else begin
      op_a = {1'b0, rem_q[REM_W-3:0], dvd_q[SUM_W-1]};
      op_b = REM_W'(dvs_q);
    end
  end

  always_comb begin
    phase_d = phase_q;
    step_d  = step_q;
    dvd_d   = dvd_q;
    dvs_d   = dvs_q;
    rem_d   = rem_q;
    root_d  = root_q;
    done_d  = 1'b0;
    case (phase_q)
      ENG_IDLE: begin
        if (start_i) begin
          phase_d = ENG_DIV;
          step_d  = '0;
          dvd_d   = dividend_i;
          dvs_d   = divisor_i;
          rem_d   = '0;
        end
      end
      ENG_DIV: begin
        rem_d  = ge ? diff : op_a;
        dvd_d  = {dvd_q[SUM_W-2:0], ge};
        step_d = step_q + 1'b1;
        if (step_q == STEP_W'(DIV_STEPS - 1)) begin
          // quotient never exceeds 2^30; park its low 32 bits at the top
          phase_d = ENG_SQRT;
          step_d  = '0;
          rem_d   = '0;
          root_d  = '0;
          dvd_d   = {dvd_q[2*ROOT_W-2:0], ge, (SUM_W - 2*ROOT_W)'(0)};
        end
      end
      ENG_SQRT: begin
        rem_d  = ge ? diff : op_a;
        root_d = {root_q[ROOT_W-2:0], ge};
        dvd_d  = {dvd_q[SUM_W-3:0], 2'b00};
        step_d = step_q + 1'b1;
        if (step_q == STEP_W'(SQRT_STEPS - 1)) begin
          phase_d = ENG_IDLE;
          done_d  = 1'b1;
        end
      end
      default: begin
        phase_d = ENG_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= ENG_IDLE;
      step_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      step_q  <= step_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q  <= dvd_d;
    dvs_q  <= dvs_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

### design/window_rms_meter.sv
// window_rms_meter top level: input handshake, window sequencer and output
// register; depends on wrm_pkg, wrm_accum and wrm_root_div
//
// Usage:
//   Samples enter on the s_axis channel, one per transfer, tlast marking the
//   final sample of a window. Within a window a sample is taken every cycle.
//   Each window yields one result on the m_axis channel: the integer RMS level
//   floor(sqrt(floor(sum of squares / count))), the saturated sample count and
//   an overflow flag raised when the window held more than 65536 samples
//   (only the first 65536 are then measured).
//   After the tlast transfer s_axis_tready stays low while the shared
//   subtractor runs a 47-step restoring divide and a 16-step square root,
//   one step per cycle. After ST_ADD and ST_LOAD hand the sum and count over,
//   the engine runs its steps and ST_DONE loads the result into the output register.
//   The result sits in an output register, so once it is loaded the next
//   window is accepted even while m_axis_tready is low; only the end of the
//   following window waits until the held result has been taken.
//   Reset clears the sum, count, flag, sequencer and m_axis_tvalid.

module window_rms_meter
  import wrm_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [15:0] sample
  input  logic                  s_axis_tlast,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [15:0] rms_level, [32:16] window_count,
                                                // [39:33] zero
  output logic                  m_axis_tuser    // [0] overflowed
);

  state_e            state_d, state_q;
  acc_t              acc;
  logic              in_fire, clear, eng_start, eng_done;
  logic [ROOT_W-1:0] root;
  logic [CNT_W-1:0]  cnt_d, cnt_q, out_cnt_d, out_cnt_q;
  logic              ovf_d, ovf_q, out_ovf_d, out_ovf_q;
  logic [ROOT_W-1:0] out_rms_d, out_rms_q;
  logic              out_vld_d, out_vld_q;

  assign s_axis_tready = (state_q == ST_ACC);
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  wrm_accum u_accum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fire_i  (in_fire),
    .sample_i(s_axis_tdata[SAMPLE_BITS-1:0]),
    .clear_i (clear),
    .acc_o   (acc)
  );

  wrm_root_div u_engine (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (eng_start),
    .dividend_i(acc.sum),
    .divisor_i (acc.count),
    .done_o    (eng_done),
    .root_o    (root)
  );

  always_comb begin
    state_d   = state_q;
    clear     = 1'b0;
    eng_start = 1'b0;
    cnt_d     = cnt_q;
    ovf_d     = ovf_q;
    out_vld_d = out_vld_q;
    out_rms_d = out_rms_q;
    out_cnt_d = out_cnt_q;
    out_ovf_d = out_ovf_q;
    if (out_vld_q && m_axis_tready) begin
      out_vld_d = 1'b0;
    end
    case (state_q)
      ST_ACC: begin
        if (in_fire && s_axis_tlast) begin
          state_d = ST_ADD;
        end
      end
      // last square lands in the sum
      ST_ADD: begin
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        eng_start = 1'b1;
        clear     = 1'b1;
        cnt_d     = acc.count;
        ovf_d     = acc.ovf;
        state_d   = ST_CALC;
      end
      ST_CALC: begin
        if (eng_done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_vld_q || m_axis_tready) begin
          out_vld_d = 1'b1;
          out_rms_d = root;
          out_cnt_d = cnt_q;
          out_ovf_d = ovf_q;
          state_d   = ST_ACC;
        end
      end
      default: begin
        state_d = ST_ACC;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_ACC;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q     <= cnt_d;
    ovf_q     <= ovf_d;
    out_rms_q <= out_rms_d;
    out_cnt_q <= out_cnt_d;
    out_ovf_q <= out_ovf_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {(OUT_DATA_W - ROOT_W - CNT_W)'(0), out_cnt_q, out_rms_q};
  assign m_axis_tuser  = out_ovf_q;

endmodule

### design/wrm_checker.sv
// window_rms_meter port checker and its bind to the top level;
// depends on wrm_pkg and window_rms_meter

module wrm_checker
  import wrm_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic                  s_axis_tlast,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,
  input logic                  m_axis_tuser
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // window end must hand over to the engine before taking more samples
  a_stall_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
    else $error("sample taken right after window end");

  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[32:16] != '0)
    else $error("result with empty window");

  a_ovf_saturated: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[32:16] == MAX_COUNT)
    else $error("overflow flag without saturated count");

endmodule

bind window_rms_meter wrm_checker u_wrm_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .s_axis_tlast (s_axis_tlast),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser)
);

### bench/rms_window_checker.sv
`timescale 1ns / 1ps
// RMS window checker: watches both stream channels of window_rms_meter, predicts
// each window's result and compares it; depends on wrm_pkg for the channel widths

module rms_window_checker
  import wrm_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  input  logic                  s_axis_tready_i,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  input  logic                  s_axis_tlast_i,
  input  logic                  m_axis_tvalid_i,
  input  logic                  m_axis_tready_i,
  input  logic [OUT_DATA_W-1:0] m_axis_tdata_i,
  input  logic                  m_axis_tuser_i,
  output int                    err_count_o,
  output int                    open_windows_o
);

  typedef struct {
    logic [ROOT_W-1:0] level;
    logic [CNT_W-1:0]  count;
    logic              ovf;
  } rms_result_t;

  rms_result_t      pending_levels[$];
  rms_result_t      want;
  longint unsigned  sq_sum;
  longint unsigned  mag;
  int unsigned      taken;
  logic             capped;
  logic signed [IN_DATA_W-1:0] smp;

  // floor square root, one result bit at a time from the top
  function automatic logic [ROOT_W:0] floor_root(input longint unsigned v);
    logic [ROOT_W:0] r;
    longint unsigned t;
    int b;
    r = '0;
    for (b = ROOT_W; b >= 0; b--) begin
      t = longint'(r) | (64'd1 << b);
      if (t * t <= v) r = t[ROOT_W:0];
    end
    return r;
  endfunction

  task automatic field_check(input string name, input longint unsigned want_v,
                             input logic [CNT_W-1:0] got_v);
    if (^got_v === 1'bx || longint'(got_v) != want_v) begin
      $display("%0t: %s expected %0d got %0d", $time, name, want_v, got_v);
      err_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_sum = 0;
      taken  = 0;
      capped = 1'b0;
      pending_levels.delete();
      open_windows_o = 0;
    end else begin
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (pending_levels.size() == 0) begin
          $display("%0t: result with no window pending, expected none got level %0d",
                   $time, m_axis_tdata_i[ROOT_W-1:0]);
          err_count_o++;
        end else begin
          want = pending_levels.pop_front();
          field_check("rms_level", 64'(want.level), CNT_W'(m_axis_tdata_i[ROOT_W-1:0]));
          field_check("window_count", 64'(want.count), m_axis_tdata_i[ROOT_W +: CNT_W]);
          field_check("overflowed", 64'(want.ovf), CNT_W'(m_axis_tuser_i));
          field_check("tdata pad", 64'd0,
                      CNT_W'(m_axis_tdata_i[OUT_DATA_W-1:ROOT_W+CNT_W]));
        end
      end

      if (s_axis_tvalid_i && s_axis_tready_i) begin
        smp = s_axis_tdata_i;
        mag = (smp < 0) ? longint'(-int'(smp)) : longint'(int'(smp));
        // once the window is full further samples only raise the flag
        if (taken >= MAX_SAMPLES) begin
          capped = 1'b1;
        end else begin
          sq_sum += mag * mag;  // at most 2^46, no saturation needed
          taken++;
        end
        if (s_axis_tlast_i) begin
          want.level = ROOT_W'(floor_root(sq_sum / taken));
          want.count = CNT_W'(taken);
          want.ovf   = capped;
          pending_levels.push_back(want);
          sq_sum = 0;
          taken  = 0;
          capped = 1'b0;
        end
      end

      open_windows_o = pending_levels.size();
    end
  end

endmodule

### bench/tb_window_rms_meter.sv
`timescale 1ns / 1ps
// testbench top for window_rms_meter: clock, reset, sample stimulus and result
// back-pressure, verdict; depends on wrm_pkg, the block and rms_window_checker

module tb_window_rms_meter;
  import wrm_pkg::*;

  localparam int LIMIT_CYCLES = 5_000_000;
  localparam int RANDOM_ITEMS = 1950;
  localparam int TAIL_CYCLES  = 80;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic                  s_axis_tlast;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tuser;

  int err_count;
  int open_windows;
  int cycles;
  int burst_left;
  int stall_mode;
  int mode_timer;
  int stall_left;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  window_rms_meter dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  rms_window_checker rms_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_i(s_axis_tready),
    .s_axis_tdata_i (s_axis_tdata),
    .s_axis_tlast_i (s_axis_tlast),
    .m_axis_tvalid_i(m_axis_tvalid),
    .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_i (m_axis_tdata),
    .m_axis_tuser_i (m_axis_tuser),
    .err_count_o    (err_count),
    .open_windows_o (open_windows)
  );

  // result side: a mode picked each time mode_timer runs out - always ready,
  // coin flip, or mostly ready with stalls of random length
  always @(negedge clk_i) begin
    if (mode_timer == 0) begin
      stall_mode = $urandom_range(0, 2);
      mode_timer = 200;
    end
    mode_timer--;
    if (stall_left > 0) begin
      stall_left--;
    end else if (stall_mode == 2 && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 12);
    end
    case (stall_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= 1'($urandom_range(0, 1));
      default: m_axis_tready <= (stall_left == 0);
    endcase
  end

  // one sample transfer; bursts of 1..32 transfers separated by random gaps
  task automatic push_sample(input logic [IN_DATA_W-1:0] smp, input logic lst);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      burst_left = $urandom_range(1, 32);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= smp;
    s_axis_tlast  <= lst;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic hold_until_drained();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (open_windows != 0) @(negedge clk_i);
    burst_left = 0;
  endtask

  initial begin
    cycles = 0;
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("tb_window_rms_meter: errors");
    $finish;
  end

  initial begin
    int k;
    int sent;
    int win_len;
    int windows;
    logic [IN_DATA_W-1:0] smp;

    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    burst_left    = 0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // single-sample windows at zero and both extremes, then a two-sample window
    push_sample(16'h0000, 1'b1);
    push_sample(16'h8000, 1'b1);
    push_sample(16'h7fff, 1'b1);
    push_sample(16'h7fff, 1'b0);
    push_sample(16'h8000, 1'b1);
    // mean floors to 2, root floors to 1
    push_sample(16'h0001, 1'b0);
    push_sample(16'hffff, 1'b0);
    push_sample(16'h0002, 1'b0);
    push_sample(16'hfffe, 1'b1);
    push_sample(16'h5555, 1'b0);
    push_sample(16'haaaa, 1'b0);
    push_sample(16'hffff, 1'b1);
    hold_until_drained();

    sent    = 0;
    windows = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 19))
        0:             win_len = $urandom_range(41, 300);
        1, 2, 3, 4, 5: win_len = $urandom_range(5, 40);
        default:       win_len = $urandom_range(1, 4);
      endcase
      for (k = 0; k < win_len; k++) begin
        case ($urandom_range(0, 9))
          6:       smp = IN_DATA_W'($urandom_range(0, 511)) - 16'd256;
          7:       smp = $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
          8:       smp = {$urandom_range(0, 1) ? 2'b10 : 2'b01, 14'($urandom)};
          9:       smp = $urandom_range(0, 1) ? 16'h0000 : 16'hffff;
          default: smp = IN_DATA_W'($urandom);
        endcase
        push_sample(smp, k == win_len - 1);
      end
      sent += win_len;
      windows++;
      if (windows == 40) hold_until_drained();
    end

    hold_until_drained();
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (err_count == 0) begin
      $display("tb_window_rms_meter: clean");
    end else begin
      $display("tb_window_rms_meter: errors");
    end
    $finish;
  end

endmodule

### files.f
design/wrm_pkg.sv
design/wrm_accum.sv
design/wrm_sub_unit.sv
design/wrm_root_div.sv
design/window_rms_meter.sv
design/wrm_checker.sv
bench/rms_window_checker.sv
bench/tb_window_rms_meter.sv
